### design/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion pipeline.
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;
    localparam int NUM_COMP  = 4;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int TRACE_W   = DATA_W + 2;
    localparam int RAD_W     = DATA_W + 3;
    localparam int RAD_MAG_W = 17;
    localparam int SQ_IN_W   = RAD_MAG_W + FRAC_BITS - 2;
    localparam int ROOT_W    = (SQ_IN_W + 1) / 2;
    localparam int SQ_REM_W  = 2 * ROOT_W + 1;
    localparam int DIV_N_W   = SQ_IN_W + 1;
    localparam int QUO_W     = 16;
    localparam int DIV_CMP_W = ROOT_W + QUO_W;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = QUO_W;

    localparam logic signed [RAD_W-1:0] ONE_RAD = RAD_W'(1 << FRAC_BITS);

    // Component slots in the result word
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;
    localparam logic [1:0] COMP_W = 2'd3;

    localparam logic [DATA_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [DATA_W-1:0] SAT_NEG = 16'h8000;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic                                 inv;
        logic [1:0]                           root_sel;
        logic [NUM_COMP-1:0][DIFF_W-1:0]      diff;
    } t_ctl;

endpackage

### design/rotation_matrix_to_quaternion.sv
// Pipelined rotation matrix to unit quaternion converter (Shepperd's method).
//
// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   m00 m01 m02 m10 m11 m12 m20 m21 m22, 16b   -
// m_axis    out  quat_x quat_y quat_z quat_w, 16b each      invalid
//
// One matrix per cycle while m_axis is not stalled; stages: select stage, 15 root stages,
// divider setup, 16 quotient stages, output register.
// The digit-by-digit square root and the restoring dividers set the depth.
// Reset clears all stage valid bits; data registers are not reset.
// A stall on m_axis freezes every stage at once; nothing is dropped.
module rotation_matrix_to_quaternion (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [143:0] i_s_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // quat_x,quat_y,quat_z,quat_w
    output logic [0:0]   o_m_tuser    // invalid
);

    localparam int NC = rmq_pkg::NUM_COMP;

    logic en;

    // ---------------- select stage ----------------
    logic signed [rmq_pkg::DATA_W-1:0]  m [3][3];
    logic signed [rmq_pkg::TRACE_W-1:0] trace;
    logic signed [rmq_pkg::RAD_W-1:0]   rad;
    logic [1:0]                         ii, jj, kk;
    rmq_pkg::t_ctl                      n_p0_ctl;
    logic [rmq_pkg::SQ_IN_W-1:0]        n_p0_x;

    logic                               r_p0_vld;
    rmq_pkg::t_ctl                      r_p0_ctl;
    logic [rmq_pkg::SQ_IN_W-1:0]        r_p0_x;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                m[r][c] = i_s_tdata[(r*3+c)*rmq_pkg::DATA_W +: rmq_pkg::DATA_W];
            end
        end
    end

    // pick branch, pivot, radicand and numerators
    always_comb begin
        trace = rmq_pkg::TRACE_W'(m[0][0]) + rmq_pkg::TRACE_W'(m[1][1])
              + rmq_pkg::TRACE_W'(m[2][2]);
        if (m[0][0] < m[1][1]) begin
            ii = (m[1][1] < m[2][2]) ? 2'd2 : 2'd1;
        end else begin
            ii = (m[0][0] < m[2][2]) ? 2'd2 : 2'd0;
        end
        case (ii)
            2'd0:    begin jj = 2'd1; kk = 2'd2; end
            2'd1:    begin jj = 2'd2; kk = 2'd0; end
            default: begin jj = 2'd0; kk = 2'd1; end
        endcase
        n_p0_ctl = '0;
        if (trace > 0) begin
            rad = rmq_pkg::RAD_W'(trace) + rmq_pkg::ONE_RAD;
            n_p0_ctl.root_sel = rmq_pkg::COMP_W;
            n_p0_ctl.diff[rmq_pkg::COMP_X] = rmq_pkg::DIFF_W'(m[2][1])
                                           - rmq_pkg::DIFF_W'(m[1][2]);
            n_p0_ctl.diff[rmq_pkg::COMP_Y] = rmq_pkg::DIFF_W'(m[0][2])
                                           - rmq_pkg::DIFF_W'(m[2][0]);
            n_p0_ctl.diff[rmq_pkg::COMP_Z] = rmq_pkg::DIFF_W'(m[1][0])
                                           - rmq_pkg::DIFF_W'(m[0][1]);
        end else begin
            rad = rmq_pkg::RAD_W'(m[ii][ii]) - rmq_pkg::RAD_W'(m[jj][jj])
                - rmq_pkg::RAD_W'(m[kk][kk]) + rmq_pkg::ONE_RAD;
            n_p0_ctl.root_sel = ii;
            n_p0_ctl.diff[rmq_pkg::COMP_W] = rmq_pkg::DIFF_W'(m[kk][jj])
                                           - rmq_pkg::DIFF_W'(m[jj][kk]);
            n_p0_ctl.diff[jj] = rmq_pkg::DIFF_W'(m[jj][ii]) + rmq_pkg::DIFF_W'(m[ii][jj]);
            n_p0_ctl.diff[kk] = rmq_pkg::DIFF_W'(m[kk][ii]) + rmq_pkg::DIFF_W'(m[ii][kk]);
        end
        n_p0_ctl.inv = (rad <= 0);
        n_p0_x = n_p0_ctl.inv ? '0
               : {rad[rmq_pkg::RAD_MAG_W-1:0], (rmq_pkg::FRAC_BITS-2)'(0)};
    end

    // ---------------- square root stages ----------------
    logic                           r_sq_vld  [rmq_pkg::SQ_STEPS];
    rmq_pkg::t_ctl                  r_sq_ctl  [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::SQ_REM_W-1:0]   r_sq_rem  [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::ROOT_W-1:0]     r_sq_root [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::SQ_REM_W-1:0]   a_sq_rem  [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::ROOT_W-1:0]     a_sq_root [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::SQ_REM_W-1:0]   sq_inc    [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::SQ_REM_W-1:0]   n_sq_rem  [rmq_pkg::SQ_STEPS];
    logic [rmq_pkg::ROOT_W-1:0]     n_sq_root [rmq_pkg::SQ_STEPS];

    // one root bit per stage: try root + 2^b against the remainder
    always_comb begin
        a_sq_rem[0]  = rmq_pkg::SQ_REM_W'(r_p0_x);
        a_sq_root[0] = '0;
        for (int s = 1; s < rmq_pkg::SQ_STEPS; s++) begin
            a_sq_rem[s]  = r_sq_rem[s-1];
            a_sq_root[s] = r_sq_root[s-1];
        end
        for (int s = 0; s < rmq_pkg::SQ_STEPS; s++) begin
            sq_inc[s] = (rmq_pkg::SQ_REM_W'(a_sq_root[s]) << (rmq_pkg::SQ_STEPS - s))
                      + (rmq_pkg::SQ_REM_W'(1) << (2 * (rmq_pkg::SQ_STEPS - 1 - s)));
            if (a_sq_rem[s] >= sq_inc[s]) begin
                n_sq_rem[s]  = a_sq_rem[s] - sq_inc[s];
                n_sq_root[s] = a_sq_root[s]
                             | (rmq_pkg::ROOT_W'(1) << (rmq_pkg::SQ_STEPS - 1 - s));
            end else begin
                n_sq_rem[s]  = a_sq_rem[s];
                n_sq_root[s] = a_sq_root[s];
            end
        end
    end

    // ---------------- divider setup ----------------
    localparam int SQL = rmq_pkg::SQ_STEPS - 1;

    logic [rmq_pkg::ROOT_W-1:0]     sq_half;
    logic [rmq_pkg::DIFF_W-1:0]     dp_mag  [NC];
    logic [rmq_pkg::DIV_N_W-1:0]    n_dp_rem [NC];
    logic [NC-1:0]                  n_dp_neg;
    logic [NC-1:0]                  n_dp_ovf;

    logic                           r_dp_vld;
    rmq_pkg::t_ctl                  r_dp_ctl;
    logic [rmq_pkg::ROOT_W-1:0]     r_dp_half;
    logic [rmq_pkg::DIV_N_W-1:0]    r_dp_rem [NC];
    logic [NC-1:0]                  r_dp_neg;
    logic [NC-1:0]                  r_dp_ovf;

    // numerator |d| * 2^(F-2) + half/2 for round-to-nearest; flag quotients >= 2^16
    always_comb begin
        sq_half = r_sq_root[SQL];
        for (int c = 0; c < NC; c++) begin
            n_dp_neg[c] = r_sq_ctl[SQL].diff[c][rmq_pkg::DIFF_W-1];
            dp_mag[c]   = n_dp_neg[c] ? (rmq_pkg::DIFF_W'(0) - r_sq_ctl[SQL].diff[c])
                                      : r_sq_ctl[SQL].diff[c];
            n_dp_rem[c] = rmq_pkg::DIV_N_W'({dp_mag[c], (rmq_pkg::FRAC_BITS-2)'(0)})
                        + rmq_pkg::DIV_N_W'(sq_half >> 1);
            n_dp_ovf[c] = rmq_pkg::DIV_CMP_W'(n_dp_rem[c])
                       >= {sq_half, rmq_pkg::QUO_W'(0)};
        end
    end

    // ---------------- quotient stages ----------------
    logic                           r_dv_vld  [rmq_pkg::DIV_STEPS];
    rmq_pkg::t_ctl                  r_dv_ctl  [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::ROOT_W-1:0]     r_dv_half [rmq_pkg::DIV_STEPS];
    logic [NC-1:0]                  r_dv_neg  [rmq_pkg::DIV_STEPS];
    logic [NC-1:0]                  r_dv_ovf  [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::DIV_N_W-1:0]    r_dv_rem  [rmq_pkg::DIV_STEPS][NC];
    logic [rmq_pkg::QUO_W-1:0]      r_dv_quo  [rmq_pkg::DIV_STEPS][NC];
    logic [rmq_pkg::DIV_N_W-1:0]    a_dv_rem  [rmq_pkg::DIV_STEPS][NC];
    logic [rmq_pkg::QUO_W-1:0]      a_dv_quo  [rmq_pkg::DIV_STEPS][NC];
    logic [rmq_pkg::ROOT_W-1:0]     a_dv_half [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::DIV_CMP_W-1:0]  dv_trial  [rmq_pkg::DIV_STEPS];
    logic [rmq_pkg::DIV_N_W-1:0]    n_dv_rem  [rmq_pkg::DIV_STEPS][NC];
    logic [rmq_pkg::QUO_W-1:0]      n_dv_quo  [rmq_pkg::DIV_STEPS][NC];

    // restoring division, one quotient bit per stage
    always_comb begin
        a_dv_half[0] = r_dp_half;
        for (int c = 0; c < NC; c++) begin
            a_dv_rem[0][c] = r_dp_rem[c];
            a_dv_quo[0][c] = '0;
        end
        for (int s = 1; s < rmq_pkg::DIV_STEPS; s++) begin
            a_dv_half[s] = r_dv_half[s-1];
            for (int c = 0; c < NC; c++) begin
                a_dv_rem[s][c] = r_dv_rem[s-1][c];
                a_dv_quo[s][c] = r_dv_quo[s-1][c];
            end
        end
        for (int s = 0; s < rmq_pkg::DIV_STEPS; s++) begin
            dv_trial[s] = rmq_pkg::DIV_CMP_W'(a_dv_half[s]) << (rmq_pkg::DIV_STEPS - 1 - s);
            for (int c = 0; c < NC; c++) begin
                if (rmq_pkg::DIV_CMP_W'(a_dv_rem[s][c]) >= dv_trial[s]) begin
                    n_dv_rem[s][c] = a_dv_rem[s][c] - rmq_pkg::DIV_N_W'(dv_trial[s]);
                    n_dv_quo[s][c] = a_dv_quo[s][c]
                                   | (rmq_pkg::QUO_W'(1) << (rmq_pkg::DIV_STEPS - 1 - s));
                end else begin
                    n_dv_rem[s][c] = a_dv_rem[s][c];
                    n_dv_quo[s][c] = a_dv_quo[s][c];
                end
            end
        end
    end

    // ---------------- output stage ----------------
    localparam int DVL = rmq_pkg::DIV_STEPS - 1;

    logic [rmq_pkg::DATA_W-1:0]     n_out_q [NC];
    logic                           r_out_vld;
    logic [rmq_pkg::DATA_W-1:0]     r_out_q [NC];
    logic                           r_out_inv;

    // place the root, saturate the quotients, zero on invalid radicand
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            if (r_dv_ctl[DVL].inv) begin
                n_out_q[c] = '0;
            end else if (r_dv_ctl[DVL].root_sel == 2'(c)) begin
                n_out_q[c] = rmq_pkg::DATA_W'(r_dv_half[DVL]);
            end else if (r_dv_neg[DVL][c]) begin
                if (r_dv_ovf[DVL][c] || r_dv_quo[DVL][c] > rmq_pkg::SAT_NEG) begin
                    n_out_q[c] = rmq_pkg::SAT_NEG;
                end else begin
                    n_out_q[c] = rmq_pkg::DATA_W'(0) - r_dv_quo[DVL][c];
                end
            end else begin
                if (r_dv_ovf[DVL][c] || r_dv_quo[DVL][c] > rmq_pkg::SAT_POS) begin
                    n_out_q[c] = rmq_pkg::SAT_POS;
                end else begin
                    n_out_q[c] = r_dv_quo[DVL][c];
                end
            end
        end
    end

    // ---------------- pipeline control ----------------
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld  <= 1'b0;
            r_dp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int s = 0; s < rmq_pkg::SQ_STEPS; s++) r_sq_vld[s] <= 1'b0;
            for (int s = 0; s < rmq_pkg::DIV_STEPS; s++) r_dv_vld[s] <= 1'b0;
        end else if (en) begin
            r_p0_vld    <= i_s_tvalid;
            r_sq_vld[0] <= r_p0_vld;
            for (int s = 1; s < rmq_pkg::SQ_STEPS; s++) r_sq_vld[s] <= r_sq_vld[s-1];
            r_dp_vld    <= r_sq_vld[SQL];
            r_dv_vld[0] <= r_dp_vld;
            for (int s = 1; s < rmq_pkg::DIV_STEPS; s++) r_dv_vld[s] <= r_dv_vld[s-1];
            r_out_vld   <= r_dv_vld[DVL];
        end
    end

    // stage data advances with the valid bits
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_ctl <= n_p0_ctl;
            r_p0_x   <= n_p0_x;
            r_sq_ctl[0] <= r_p0_ctl;
            for (int s = 1; s < rmq_pkg::SQ_STEPS; s++) r_sq_ctl[s] <= r_sq_ctl[s-1];
            for (int s = 0; s < rmq_pkg::SQ_STEPS; s++) begin
                r_sq_rem[s]  <= n_sq_rem[s];
                r_sq_root[s] <= n_sq_root[s];
            end
            r_dp_ctl  <= r_sq_ctl[SQL];
            r_dp_half <= sq_half;
            r_dp_neg  <= n_dp_neg;
            r_dp_ovf  <= n_dp_ovf;
            for (int c = 0; c < NC; c++) r_dp_rem[c] <= n_dp_rem[c];
            r_dv_ctl[0]  <= r_dp_ctl;
            r_dv_half[0] <= r_dp_half;
            r_dv_neg[0]  <= r_dp_neg;
            r_dv_ovf[0]  <= r_dp_ovf;
            for (int s = 1; s < rmq_pkg::DIV_STEPS; s++) begin
                r_dv_ctl[s]  <= r_dv_ctl[s-1];
                r_dv_half[s] <= r_dv_half[s-1];
                r_dv_neg[s]  <= r_dv_neg[s-1];
                r_dv_ovf[s]  <= r_dv_ovf[s-1];
            end
            for (int s = 0; s < rmq_pkg::DIV_STEPS; s++) begin
                for (int c = 0; c < NC; c++) begin
                    r_dv_rem[s][c] <= n_dv_rem[s][c];
                    r_dv_quo[s][c] <= n_dv_quo[s][c];
                end
            end
            for (int c = 0; c < NC; c++) r_out_q[c] <= n_out_q[c];
            r_out_inv <= r_dv_ctl[DVL].inv;
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = {r_out_q[3], r_out_q[2], r_out_q[1], r_out_q[0]};
    assign o_m_tuser[0] = r_out_inv;

    // ---------------- checks ----------------
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("invalid result carries nonzero components");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dp_vld && !r_dp_ctl.inv |-> r_dp_half != '0)
        else $error("positive radicand produced a zero root");

    a_inv_from_rad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p0_vld |-> (r_p0_ctl.inv == (r_p0_x == '0)))
        else $error("invalid flag disagrees with radicand");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule
